// ===== rtl/cfa_pkg.sv =====
// Shared types and constants of the contiguous frame allocator.
package cfa_pkg;

  // Default number of frames held in the frame map.
  localparam int FRAME_COUNT_DEF = 1024;

  // Field widths fixed by the request and result formats.
  localparam int CFG_W      = 11;
  localparam int COUNT_W    = 11;
  localparam int FRAME_W    = 10;
  localparam int CFG_IDX_W  = 1;
  // Address width carried between sequencer and map, enough for the largest map.
  localparam int MAP_ADDR_W = 17;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] FRAMES_PRESENT_RST  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RESERVED_FRAMES_RST = '0;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_PRESENT = 1'b0,
    REG_RESERVED       = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                operation;
    logic [COUNT_W-1:0] page_count;
    logic [FRAME_W-1:0] start_frame;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame_index;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] frames_present;
    logic [CFG_W-1:0] reserved_frames;
  } cfg_t;

  // Access request from the sequencer to the two frame map memories.
  typedef struct packed {
    logic                  used_we;
    logic                  used_wdata;
    logic [MAP_ADDR_W-1:0] used_addr;
    logic                  run_we;
    logic [COUNT_W-1:0]    run_wdata;
    logic [MAP_ADDR_W-1:0] run_addr;
  } map_req_t;

endpackage

// ===== rtl/cfa_frame_map.sv =====
// Frame map: used-bit memory and run-length memory, one port each.
module cfa_frame_map #(
  parameter int FRAME_COUNT = cfa_pkg::FRAME_COUNT_DEF
) (
  input  logic                         clk,
  input  cfa_pkg::map_req_t            map_req,
  output logic                         used_rdata,
  output logic [cfa_pkg::COUNT_W-1:0]  run_rdata
);

  localparam int AW = $clog2(FRAME_COUNT);

  logic                        used_mem [FRAME_COUNT];
  logic [cfa_pkg::COUNT_W-1:0] run_mem  [FRAME_COUNT];

  // Used bits: write when enabled, registered read of the old contents.
  always_ff @(posedge clk) begin
    if (map_req.used_we) begin
      used_mem[map_req.used_addr[AW-1:0]] <= map_req.used_wdata;
    end
    used_rdata <= used_mem[map_req.used_addr[AW-1:0]];
  end

  // Run lengths, nonzero only at the first frame of an allocated run.
  always_ff @(posedge clk) begin
    if (map_req.run_we) begin
      run_mem[map_req.run_addr[AW-1:0]] <= map_req.run_wdata;
    end
    run_rdata <= run_mem[map_req.run_addr[AW-1:0]];
  end

endmodule

// ===== rtl/cfa_seq.sv =====
// Sequencer: clearing pass, first-fit scan, run marking and run freeing.
module cfa_seq #(
  parameter int FRAME_COUNT = cfa_pkg::FRAME_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfa_pkg::cfg_t                cfg,
  input  logic                         start,
  input  cfa_pkg::req_t                request,
  output logic                         busy,
  output logic                         done,
  output cfa_pkg::rsp_t                result,
  output cfa_pkg::map_req_t            map_req,
  input  logic                         used_rdata,
  input  logic [cfa_pkg::COUNT_W-1:0]  run_rdata
);

  localparam int PW = $clog2(FRAME_COUNT + 1);
  localparam int XW = (PW > 12) ? PW : 12;
  localparam int CW = cfa_pkg::COUNT_W;
  localparam int FW = cfa_pkg::FRAME_W;
  localparam int AW = cfa_pkg::MAP_ADDR_W;

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_SCAN     = 6'b000100,
    S_MARK     = 6'b001000,
    S_FREE_RD  = 6'b010000,
    S_FREE_CLR = 6'b100000
  } state_t;

  state_t         state;
  logic [XW-1:0]  limit;
  logic [XW-1:0]  clr;
  logic [XW-1:0]  pos;
  logic [XW-1:0]  cidx;
  logic [XW-1:0]  first;
  logic [XW-1:0]  mk;
  logic [XW-1:0]  mk_end;
  logic [XW-1:0]  kpos;
  logic [CW-1:0]  want;
  logic [CW-1:0]  run;
  logic [CW-1:0]  len;
  logic [CW-1:0]  cnt;
  logic [FW-1:0]  fstart;
  logic           pending;
  logic           first_cyc;
  logic           frame_busy;
  logic           hit;
  logic           past_end;

  // Effective frame count is the smaller of the register and the map depth.
  always_comb begin
    if (XW'(cfg.frames_present) < XW'(FRAME_COUNT)) begin
      limit = XW'(cfg.frames_present);
    end else begin
      limit = XW'(FRAME_COUNT);
    end
  end

  // Scan check of the frame whose used bit has just come back.
  assign frame_busy = (cidx < XW'(cfg.reserved_frames)) || used_rdata;
  assign hit        = !frame_busy && ((run + CW'(1)) == want);
  assign past_end   = (cidx >= limit);

  assign busy = (state != S_IDLE);

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + XW'(1);
          if (clr == XW'(FRAME_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (request.operation == cfa_pkg::OP_ALLOC) begin
              want <= request.page_count;
              if ((request.page_count == '0) || (XW'(request.page_count) > limit)) begin
                done               <= 1'b1;
                result.status      <= cfa_pkg::ST_NOSPACE;
                result.frame_index <= '0;
              end else begin
                pos     <= '0;
                run     <= '0;
                pending <= 1'b0;
                state   <= S_SCAN;
              end
            end else begin
              fstart <= request.start_frame;
              if (XW'(request.start_frame) >= limit) begin
                done               <= 1'b1;
                result.status      <= cfa_pkg::ST_BADFREE;
                result.frame_index <= request.start_frame;
              end else begin
                state <= S_FREE_RD;
              end
            end
          end
        end
        S_SCAN: begin
          pos     <= pos + XW'(1);
          cidx    <= pos;
          pending <= 1'b1;
          if (pending) begin
            if (past_end) begin
              done               <= 1'b1;
              result.status      <= cfa_pkg::ST_NOSPACE;
              result.frame_index <= '0;
              state              <= S_IDLE;
            end else if (frame_busy) begin
              run <= '0;
            end else if (hit) begin
              first     <= cidx + XW'(1) - XW'(want);
              mk        <= cidx + XW'(1) - XW'(want);
              mk_end    <= cidx;
              first_cyc <= 1'b1;
              state     <= S_MARK;
            end else begin
              run <= run + CW'(1);
            end
          end
        end
        S_MARK: begin
          first_cyc <= 1'b0;
          mk        <= mk + XW'(1);
          if (mk == mk_end) begin
            done               <= 1'b1;
            result.status      <= cfa_pkg::ST_OK;
            result.frame_index <= first[FW-1:0];
            state              <= S_IDLE;
          end
        end
        S_FREE_RD: begin
          if (run_rdata == '0) begin
            done               <= 1'b1;
            result.status      <= cfa_pkg::ST_BADFREE;
            result.frame_index <= fstart;
            state              <= S_IDLE;
          end else begin
            len   <= run_rdata;
            kpos  <= XW'(fstart);
            cnt   <= CW'(1);
            state <= S_FREE_CLR;
          end
        end
        S_FREE_CLR: begin
          kpos <= kpos + XW'(1);
          cnt  <= cnt + CW'(1);
          if ((cnt == len) || (kpos == XW'(FRAME_COUNT - 1))) begin
            done               <= 1'b1;
            result.status      <= cfa_pkg::ST_OK;
            result.frame_index <= fstart;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          clr   <= '0;
        end
      endcase
    end
  end

  // Memory accesses for each state.
  always_comb begin
    map_req = '0;
    unique case (state)
      S_CLEAR: begin
        map_req.used_we   = 1'b1;
        map_req.used_addr = AW'(clr);
        map_req.run_we    = 1'b1;
        map_req.run_addr  = AW'(clr);
      end
      S_IDLE: begin
        // Look up the run length early in case this is a free request.
        map_req.run_addr = AW'(request.start_frame);
      end
      S_SCAN: begin
        map_req.used_addr = AW'(pos);
      end
      S_MARK: begin
        map_req.used_we    = 1'b1;
        map_req.used_wdata = 1'b1;
        map_req.used_addr  = AW'(mk);
        map_req.run_we     = first_cyc;
        map_req.run_wdata  = want;
        map_req.run_addr   = AW'(first);
      end
      S_FREE_RD: begin
        map_req.run_we   = (run_rdata != '0);
        map_req.run_addr = AW'(fstart);
      end
      S_FREE_CLR: begin
        map_req.used_we   = 1'b1;
        map_req.used_addr = AW'(kpos);
      end
      default: begin
        map_req = '0;
      end
    endcase
  end

endmodule

// ===== rtl/contiguous_frame_allocator_top.sv =====
// Top level of the first-fit contiguous frame allocator.
//
//   channel  | signals                          | transfer
//   ---------+----------------------------------+-------------------------------
//   request  | start, busy, request             | start high while busy is low
//   result   | done, result                     | done high for one cycle
//   config   | cfg_we, cfg_index, cfg_data      | cfg_we high, no wait
//
// After reset the block clears the frame map, with busy high until the clearing pass ends.
// An allocate request that finds no fit scans all min(frames_present, FRAME_COUNT) frames
// before it answers; one whose run ends at frame f scans up to frame f, then marks
// its page_count frames. The single-port used-bit memory visits or marks one frame per cycle.
// A free request reads the run length, then clears the used bit of each frame of the run,
// and requests rejected at once answer in the next cycle. The receiver cannot stall results.
module contiguous_frame_allocator_top #(
  parameter int FRAME_COUNT = cfa_pkg::FRAME_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  cfa_pkg::req_t                  request,
  output logic                           busy,
  output logic                           done,
  output cfa_pkg::rsp_t                  result,
  input  logic                           cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfa_pkg::CFG_W-1:0]      cfg_data
);

  cfa_pkg::cfg_t                cfg;
  cfa_pkg::map_req_t            map_req;
  logic                         used_rdata;
  logic [cfa_pkg::COUNT_W-1:0]  run_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frames_present  <= cfa_pkg::FRAMES_PRESENT_RST;
      cfg.reserved_frames <= cfa_pkg::RESERVED_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfa_pkg::cfg_reg_t'(cfg_index))
        cfa_pkg::REG_FRAMES_PRESENT: cfg.frames_present  <= cfg_data;
        cfa_pkg::REG_RESERVED:       cfg.reserved_frames <= cfg_data;
      endcase
    end
  end

  cfa_seq #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .request    (request),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .map_req    (map_req),
    .used_rdata (used_rdata),
    .run_rdata  (run_rdata)
  );

  cfa_frame_map #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_frame_map (
    .clk        (clk),
    .map_req    (map_req),
    .used_rdata (used_rdata),
    .run_rdata  (run_rdata)
  );

endmodule

// ===== tb/tb_contiguous_frame_allocator_top.sv =====
// Self-checking testbench for the first-fit contiguous frame allocator.
module tb_contiguous_frame_allocator_top;

  localparam int FRAMES = cfa_pkg::FRAME_COUNT_DEF;
  localparam int RANDOM_PER_PHASE = 93;
  localparam int PHASES = 6;
  localparam int CW = cfa_pkg::COUNT_W;
  localparam int FW = cfa_pkg::FRAME_W;
  localparam int GW = cfa_pkg::CFG_W;

  logic                          clk;
  logic                          rst;
  logic                          start;
  cfa_pkg::req_t                 request;
  logic                          busy;
  logic                          done;
  cfa_pkg::rsp_t                 result;
  logic                          cfg_we;
  logic [cfa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [GW-1:0]                 cfg_data;

  contiguous_frame_allocator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the frame map and the register file.
  bit               frame_used [FRAMES];
  logic [CW-1:0]    run_len  [FRAMES];
  logic [GW-1:0]    frames_present_q;
  logic [GW-1:0]    reserved_q;

  cfa_pkg::req_t request_backlog [$];
  cfa_pkg::rsp_t pending_answers [$];
  cfa_pkg::rsp_t answer;

  int unsigned issued_count;
  int unsigned taken_count;
  int unsigned gap_left;
  bit          burst_mode;
  int unsigned mismatches;
  int unsigned alloc_ok, free_ok, no_space, bad_free, settings_used;

  // Computes the answer to one request and updates the shadow frame map.
  function automatic cfa_pkg::rsp_t frame_map_answer(cfa_pkg::req_t r);
    cfa_pkg::rsp_t rsp;
    int unsigned   lim, run, i, first, k, len;
    bit            found;
    lim = (frames_present_q < FRAMES) ? 32'(frames_present_q) : FRAMES;
    rsp.status      = cfa_pkg::ST_NOSPACE;
    rsp.frame_index = '0;
    found = 1'b0;
    run   = 0;
    first = 0;
    if (r.operation == cfa_pkg::OP_ALLOC) begin
      if (r.page_count != 0 && r.page_count <= lim) begin
        for (i = 0; i < lim; i++) begin
          if (!found) begin
            if (i < reserved_q || frame_used[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == r.page_count) begin
                found = 1'b1;
                first = i + 1 - run;
              end
            end
          end
        end
        if (found) begin
          for (k = first; k < first + r.page_count; k++) frame_used[k] = 1'b1;
          run_len[first]  = r.page_count;
          rsp.status      = cfa_pkg::ST_OK;
          rsp.frame_index = first[FW-1:0];
        end
      end
    end else begin
      rsp.frame_index = r.start_frame;
      if (r.start_frame >= lim || run_len[r.start_frame] == 0) begin
        rsp.status = cfa_pkg::ST_BADFREE;
      end else begin
        len = 32'(run_len[r.start_frame]);
        run_len[r.start_frame] = '0;
        for (k = 0; k < len && r.start_frame + k < FRAMES; k++)
          frame_used[r.start_frame + k] = 1'b0;
        rsp.status = cfa_pkg::ST_OK;
      end
    end
    return rsp;
  endfunction

  // Draws a random request: mostly sensible allocations and frees of live runs.
  function automatic cfa_pkg::req_t draw_request();
    cfa_pkg::req_t r;
    int unsigned   roll, f;
    int unsigned   live [$];
    r.page_count  = CW'($urandom);
    r.start_frame = FW'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 47) begin
      r.operation = cfa_pkg::OP_ALLOC;
      case ($urandom_range(0, 9))
        0:       r.page_count = CW'($urandom_range(0, 2047));
        1:       r.page_count = CW'($urandom_range(33, 1024));
        default: r.page_count = CW'($urandom_range(1, 32));
      endcase
    end else begin
      r.operation = cfa_pkg::OP_FREE;
      if (roll < 88) begin
        for (f = 0; f < FRAMES; f++)
          if (run_len[f] != 0) live.push_back(f);
        if (live.size() != 0)
          r.start_frame = FW'(live[$urandom_range(0, live.size() - 1)]);
      end
    end
    return r;
  endfunction

  task automatic queue_request(input cfa_pkg::op_t op, input int unsigned count,
                               input int unsigned frame);
    cfa_pkg::req_t r;
    r.operation   = op;
    r.page_count  = count[CW-1:0];
    r.start_frame = frame[FW-1:0];
    request_backlog.push_back(r);
  endtask

  // Returns at a falling edge once nothing is queued, outstanding or in progress.
  task automatic wait_idle();
    while (request_backlog.size() != 0 || issued_count != taken_count ||
           pending_answers.size() != 0 || busy)
      @(negedge clk);
  endtask

  task automatic apply_setting(input int unsigned fp, input int unsigned rsv);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= cfa_pkg::REG_FRAMES_PRESENT;
    cfg_data  <= fp[GW-1:0];
    @(negedge clk);
    cfg_index <= cfa_pkg::REG_RESERVED;
    cfg_data  <= rsv[GW-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  task automatic report(input string what, input cfa_pkg::rsp_t want,
                        input cfa_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected status %0d frame %0d, got status %0d frame %0d",
               $realtime, what, want.status, want.frame_index, got.status,
               got.frame_index);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request driver: presents one request at a time with random gaps between them.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && issued_count != taken_count) begin
        // The current request has not been taken yet, so hold it.
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left = gap_left - 1;
      end else if (request_backlog.size() != 0) begin
        request <= request_backlog.pop_front();
        start   <= 1'b1;
        issued_count = issued_count + 1;
        if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
        gap_left = burst_mode ? 0 : $urandom_range(0, 15);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction and predicts new requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          report("result with no request outstanding", '0, result);
        end else begin
          answer = pending_answers.pop_front();
          if (result.status !== answer.status || result.frame_index !== answer.frame_index)
            report("result mismatch", answer, result);
        end
      end
      if (cfg_we) begin
        case (cfa_pkg::cfg_reg_t'(cfg_index))
          cfa_pkg::REG_FRAMES_PRESENT: frames_present_q = cfg_data;
          cfa_pkg::REG_RESERVED:       reserved_q = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        answer = frame_map_answer(request);
        pending_answers.push_back(answer);
        taken_count = taken_count + 1;
        if (answer.status == cfa_pkg::ST_NOSPACE) no_space++;
        else if (answer.status == cfa_pkg::ST_BADFREE) bad_free++;
        else if (request.operation == cfa_pkg::OP_ALLOC) alloc_ok++;
        else free_ok++;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned p, n;
    int unsigned fp_set  [PHASES];
    int unsigned rsv_set [PHASES];
    fp_set    = '{1024, 300, 2047, 1, 48, 777};
    rsv_set   = '{0, 17, 600, 0, 2, 5};
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_we    = 1'b0;
    cfg_index = cfa_pkg::REG_FRAMES_PRESENT;
    cfg_data  = '0;
    frames_present_q = cfa_pkg::FRAMES_PRESENT_RST;
    reserved_q       = cfa_pkg::RESERVED_FRAMES_RST;
    for (n = 0; n < FRAMES; n++) begin
      frame_used[n] = 1'b0;
      run_len[n]    = '0;
    end
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: edges of the counts, bad frees, a full map.
    queue_request(cfa_pkg::OP_ALLOC, 1, 0);
    queue_request(cfa_pkg::OP_ALLOC, 1024, 0);
    queue_request(cfa_pkg::OP_ALLOC, 0, 1023);
    queue_request(cfa_pkg::OP_ALLOC, 2047, 0);
    queue_request(cfa_pkg::OP_ALLOC, 3, 0);
    queue_request(cfa_pkg::OP_FREE, 0, 2);
    queue_request(cfa_pkg::OP_FREE, 0, 1);
    queue_request(cfa_pkg::OP_FREE, 2047, 1);
    queue_request(cfa_pkg::OP_FREE, 0, 1023);
    queue_request(cfa_pkg::OP_FREE, 0, 0);
    queue_request(cfa_pkg::OP_ALLOC, 1024, 0);
    queue_request(cfa_pkg::OP_ALLOC, 1, 0);
    queue_request(cfa_pkg::OP_FREE, 0, 0);
    queue_request(cfa_pkg::OP_ALLOC, 1023, 0);
    queue_request(cfa_pkg::OP_ALLOC, 1, 0);
    queue_request(cfa_pkg::OP_FREE, 0, 0);
    queue_request(cfa_pkg::OP_ALLOC, 40, 0);

    // Shrunk frame count: a run start beyond the limit is rejected, a run
    // crossing the limit is freed completely.
    apply_setting(16, 0);
    queue_request(cfa_pkg::OP_FREE, 0, 1023);
    queue_request(cfa_pkg::OP_FREE, 0, 0);
    queue_request(cfa_pkg::OP_ALLOC, 16, 0);

    // Everything reserved: nothing can be allocated, existing runs still free.
    apply_setting(2047, 2047);
    queue_request(cfa_pkg::OP_ALLOC, 1, 0);
    queue_request(cfa_pkg::OP_FREE, 0, 0);
    queue_request(cfa_pkg::OP_FREE, 0, 1023);

    // No frames at all.
    apply_setting(0, 0);
    queue_request(cfa_pkg::OP_ALLOC, 1, 0);
    queue_request(cfa_pkg::OP_FREE, 0, 0);

    // Random phases, each under its own register setting.
    for (p = 0; p < PHASES; p++) begin
      apply_setting(fp_set[p], rsv_set[p]);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        while (request_backlog.size() >= 2) @(negedge clk);
        request_backlog.push_back(draw_request());
      end
    end

    wait_idle();
    repeat (1100) @(negedge clk);

    $display("Covered %0d requests under %0d register settings:", taken_count,
             settings_used);
    $display("  %0d allocations, %0d frees, %0d without space, %0d bad frees",
             alloc_ok, free_ok, no_space, bad_free);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_answers.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung block.
  initial begin
    #150_000_000;
    $display("Timeout with %0d results outstanding", pending_answers.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
